// ----- rtl/tqle_pkg.sv -----
// ----------------------------------------------------------------------------
// tqle_pkg
// Types and constants shared by the tabular Q-learning engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tqle_pkg;

   localparam int GAIN_W   = 17;
   localparam int ACTCFG_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [GAIN_W-1:0]   GAIN_ONE        = 17'h10000;
   localparam logic [GAIN_W-1:0]   DISCOUNT_RST    = 17'd58982;
   localparam logic [GAIN_W-1:0]   LEARN_RATE_RST  = 17'd32768;
   localparam logic [GAIN_W-1:0]   EXPLORE_RST     = 17'd13107;
   localparam logic [ACTCFG_W-1:0] ACTIONS_RST     = 5'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_DISCOUNT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPLORE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIONS    = 2'd3;

   typedef struct packed {
      logic               op;
      logic [9:0]         current_state;
      logic [3:0]         action_taken;
      logic [9:0]         next_state;
      logic signed [31:0] reward;
      logic [15:0]        random_fraction;
      logic [15:0]        random_pick;
   } req_type;

   typedef struct packed {
      logic [3:0]         chosen_action;
      logic               was_random;
      logic signed [31:0] updated_value;
   } rsp_type;

   typedef enum logic [1:0] {
      RES_BEST,
      RES_RAND,
      RES_UPD
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        clear_step;
      logic        addr_calc;
      logic        scan_rd;
      logic        scan_row_next;
      logic        q_rd;
      logic        mul1;
      logic        q_latch;
      logic        tgt;
      logic        mul2;
      logic        sum;
      logic        q_wr;
      logic        rsp_load;
      res_sel_type res_sel;
   } cmd_type;

   typedef struct packed {
      logic mod_done;
      logic explore;
      logic op;
      logic clear_last;
   } stat_type;

   // gains above 1.0 act as 1.0
   function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
      logic [GAIN_W-1:0] r;
      r = (g > GAIN_ONE) ? GAIN_ONE : g;
      return r;
   endfunction

endpackage

// ----- rtl/tqle_mod.sv -----
// ----------------------------------------------------------------------------
// tqle_mod
// Iterative remainder unit: restoring reduction, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqle_mod #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] rem,
   output logic             done
);

   localparam int KW = (NUM_W > 1) ? $clog2(NUM_W) : 1;
   localparam int XW = NUM_W + DEN_W;

   logic [NUM_W-1:0] r_ff, r_in;
   logic [DEN_W-1:0] d_ff;
   logic [KW-1:0]    k_ff;
   logic             busy_ff;
   logic [XW-1:0]    sh;
   logic [XW-1:0]    wide_r;

   assign sh     = {{NUM_W{1'b0}}, d_ff} << k_ff;
   assign wide_r = {{DEN_W{1'b0}}, r_ff};
   assign r_in   = (wide_r >= sh) ? (r_ff - sh[NUM_W-1:0]) : r_ff;
   assign done   = busy_ff && (k_ff == '0);
   assign rem    = r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         k_ff    <= KW'(NUM_W - 1);
      end else if (busy_ff) begin
         if (k_ff == '0) begin
            busy_ff <= 1'b0;
         end else begin
            k_ff <= k_ff - KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff <= num;
         d_ff <= den;
      end else if (busy_ff) begin
         r_ff <= r_in;
      end
   end

endmodule

// ----- rtl/tqle_dp.sv -----
// ----------------------------------------------------------------------------
// tqle_dp
// Datapath: Q table memory, config registers, index reduction, max scan and
// the fixed-point update arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqle_dp import tqle_pkg::*; #(
   parameter int NUM_STATES  = 1024,
   parameter int NUM_ACTIONS = 16,
   localparam int DEPTH = NUM_STATES * NUM_ACTIONS,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int AIW   = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1,
   localparam int CW    = $clog2(NUM_ACTIONS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [GAIN_W-1:0]     csr_data,
   input  cmd_type               cmd,
   input  logic [AIW-1:0]        scan_idx,
   output stat_type              stat,
   output logic [CW-1:0]         live,
   output rsp_type               rsp_data
);

   localparam logic signed [49:0] RND1 = 50'sd32768;
   localparam logic signed [53:0] RND2 = 54'sd32768;
   localparam logic signed [38:0] SAT_MAX = 39'sd2147483647;
   localparam logic signed [38:0] SAT_MIN = -39'sd2147483648;

   // reciprocal constants for the index reduction; a zero pair passes the
   // index through when the modulus already covers the field range
   localparam logic [20:0] ST_RECIP  = (NUM_STATES >= 1024) ? 21'd0
                                       : 21'(((1 << 20) + NUM_STATES - 1) / NUM_STATES);
   localparam logic [10:0] ST_DEN    = (NUM_STATES >= 1024) ? 11'd0 : 11'(NUM_STATES);
   localparam logic [20:0] ACT_RECIP = (NUM_ACTIONS >= 16) ? 21'd0
                                       : 21'(((1 << 20) + NUM_ACTIONS - 1) / NUM_ACTIONS);
   localparam logic [10:0] ACT_DEN   = (NUM_ACTIONS >= 16) ? 11'd0 : 11'(NUM_ACTIONS);

   // v mod den for a 10-bit v: quotient by reciprocal multiply, exact for
   // any modulus below 1024, then subtract the back product
   function automatic logic [9:0] reduce_idx(input logic [9:0]  v,
                                             input logic [20:0] recip,
                                             input logic [10:0] den);
      logic [30:0] prod;
      logic [20:0] back;
      logic [9:0]  r;
      prod = 31'(v) * 31'(recip);
      back = 21'(prod[30:20]) * 21'(den);
      r    = 10'(21'(v) - back);
      return r;
   endfunction

   // config registers
   logic [GAIN_W-1:0]   discount_ff, learn_rate_ff, explore_ff;
   logic [ACTCFG_W-1:0] actions_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         discount_ff   <= DISCOUNT_RST;
         learn_rate_ff <= LEARN_RATE_RST;
         explore_ff    <= EXPLORE_RST;
         actions_ff    <= ACTIONS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DISCOUNT:   discount_ff   <= csr_data;
            CSR_LEARN_RATE: learn_rate_ff <= csr_data;
            CSR_EXPLORE:    explore_ff    <= csr_data;
            CSR_ACTIONS:    actions_ff    <= csr_data[ACTCFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (actions_ff == '0) begin
         live = CW'(1);
      end else if (7'(actions_ff) > 7'(NUM_ACTIONS)) begin
         live = CW'(NUM_ACTIONS);
      end else begin
         live = CW'(actions_ff);
      end
   end

   // item registers
   logic               op_ff, explore_hit_ff;
   logic signed [31:0] reward_ff;
   logic [9:0]         cur_raw_ff, nxt_raw_ff;
   logic [3:0]         act_raw_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff          <= req_data.op;
         reward_ff      <= req_data.reward;
         explore_hit_ff <= {1'b0, req_data.random_fraction} < clamp_gain(explore_ff);
         cur_raw_ff     <= req_data.current_state;
         nxt_raw_ff     <= req_data.next_state;
         act_raw_ff     <= req_data.action_taken;
      end
   end

   // state and action reduction, settled long before the address step
   logic [9:0] cur_idx_ff, nxt_idx_ff, act_idx_ff;

   always_ff @(posedge clock) begin
      cur_idx_ff <= reduce_idx(cur_raw_ff, ST_RECIP, ST_DEN);
      nxt_idx_ff <= reduce_idx(nxt_raw_ff, ST_RECIP, ST_DEN);
      act_idx_ff <= reduce_idx(10'(act_raw_ff), ACT_RECIP, ACT_DEN);
   end

   // exploratory pick: the live action count is a register, so iterate
   logic [15:0] rem_pick;
   logic        done_pick;

   tqle_mod #(.NUM_W(16), .DEN_W(17)) u_mod_pick (
      .clock(clock), .reset(reset), .start(cmd.load),
      .num(req_data.random_pick), .den(17'(live)),
      .rem(rem_pick), .done(done_pick)
   );

   // addresses
   logic [AW-1:0] cur_base_ff, nxt_base_ff, q_addr_ff;
   logic [3:0]    pick_ff;

   always_ff @(posedge clock) begin
      if (cmd.addr_calc) begin
         cur_base_ff <= AW'(cur_idx_ff) * AW'(NUM_ACTIONS);
         nxt_base_ff <= AW'(nxt_idx_ff) * AW'(NUM_ACTIONS);
         q_addr_ff   <= AW'(cur_idx_ff) * AW'(NUM_ACTIONS) + AW'(act_idx_ff);
         pick_ff     <= rem_pick[3:0];
      end
   end

   // clearing pass counter
   logic [AW-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   // Q table
   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rdata_ff;
   logic [AW-1:0]      raddr;
   logic               rd_en;
   logic signed [38:0] nv_ff;

   assign rd_en = cmd.scan_rd || cmd.q_rd;
   assign raddr = cmd.q_rd ? q_addr_ff
                           : ((cmd.scan_row_next ? nxt_base_ff : cur_base_ff) + AW'(scan_idx));

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         mem[clr_addr_ff] <= '0;
      end else if (cmd.q_wr) begin
         mem[q_addr_ff] <= 32'(nv_ff);
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   // max scan over the row, first maximum wins
   logic               rd_scan_ff;
   logic [AIW-1:0]     rd_idx_ff;
   logic signed [31:0] best_ff;
   logic [AIW-1:0]     best_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_scan_ff <= 1'b0;
      end else begin
         rd_scan_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx;
      if (rd_scan_ff && ((rd_idx_ff == '0) || (rdata_ff > best_ff))) begin
         best_ff     <= rdata_ff;
         best_idx_ff <= rd_idx_ff;
      end
   end

   // update arithmetic
   logic signed [49:0] prod1_ff, rnd1;
   logic signed [31:0] q_ff;
   logic signed [35:0] diff_ff;
   logic signed [53:0] prod2_ff, rnd2;
   logic signed [38:0] nv_in, sum_raw;

   assign rnd1    = (prod1_ff + RND1) >>> 16;
   assign rnd2    = (prod2_ff + RND2) >>> 16;
   assign sum_raw = 39'(q_ff) + 39'(rnd2);

   always_comb begin
      if (sum_raw > SAT_MAX) begin
         nv_in = SAT_MAX;
      end else if (sum_raw < SAT_MIN) begin
         nv_in = SAT_MIN;
      end else begin
         nv_in = sum_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         prod1_ff <= $signed({1'b0, clamp_gain(discount_ff)}) * best_ff;
      end
      if (cmd.q_latch) begin
         q_ff <= rdata_ff;
      end
      if (cmd.tgt) begin
         diff_ff <= 36'(reward_ff) + 36'(rnd1) - 36'(q_ff);
      end
      if (cmd.mul2) begin
         prod2_ff <= $signed({1'b0, clamp_gain(learn_rate_ff)}) * diff_ff;
      end
      if (cmd.sum) begin
         nv_ff <= nv_in;
      end
   end

   // result register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         case (cmd.res_sel)
            RES_RAND: rsp_ff <= '{chosen_action: pick_ff, was_random: 1'b1,
                                  updated_value: '0};
            RES_BEST: rsp_ff <= '{chosen_action: 4'(best_idx_ff), was_random: 1'b0,
                                  updated_value: '0};
            RES_UPD:  rsp_ff <= '{chosen_action: 4'd0, was_random: 1'b0,
                                  updated_value: 32'(nv_ff)};
            default:  rsp_ff <= '0;
         endcase
      end
   end

   assign rsp_data        = rsp_ff;
   assign stat.mod_done   = done_pick;
   assign stat.explore    = explore_hit_ff;
   assign stat.op         = op_ff;
   assign stat.clear_last = (clr_addr_ff == AW'(DEPTH - 1));

endmodule

// ----- rtl/tqle_ctrl.sv -----
// ----------------------------------------------------------------------------
// tqle_ctrl
// Sequencer: clearing pass, item sequencing and result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tqle_ctrl import tqle_pkg::*; #(
   parameter int NUM_ACTIONS = 16,
   localparam int AIW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1,
   localparam int CW  = $clog2(NUM_ACTIONS + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  stat_type       stat,
   input  logic [CW-1:0]  live,
   output cmd_type        cmd,
   output logic [AIW-1:0] scan_idx
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MOD, ST_ADDR, ST_SCAN, ST_SCAN_WAIT, ST_RDQ,
      ST_QLAT, ST_TGT, ST_MUL2, ST_SUM, ST_WR, ST_RESULT
   } state_type;

   state_type   state_ff;
   logic        rsp_valid_ff;
   logic [CW-1:0] scan_idx_ff;
   res_sel_type res_sel_ff;
   logic        row_next_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_idx  = scan_idx_ff[AIW-1:0];

   always_comb begin
      cmd = '0;
      cmd.res_sel = res_sel_ff;
      case (state_ff)
         ST_CLEAR:  cmd.clear_step = 1'b1;
         ST_IDLE:   cmd.load       = req_valid;
         ST_ADDR:   cmd.addr_calc  = 1'b1;
         ST_SCAN: begin
            cmd.scan_rd       = 1'b1;
            cmd.scan_row_next = row_next_ff;
         end
         ST_RDQ: begin
            cmd.q_rd = 1'b1;
            cmd.mul1 = 1'b1;
         end
         ST_QLAT:   cmd.q_latch  = 1'b1;
         ST_TGT:    cmd.tgt      = 1'b1;
         ST_MUL2:   cmd.mul2     = 1'b1;
         ST_SUM:    cmd.sum      = 1'b1;
         ST_WR:     cmd.q_wr     = 1'b1;
         ST_RESULT: cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
         res_sel_ff   <= RES_BEST;
         row_next_ff  <= 1'b0;
      end else begin
         if ((state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               if (stat.mod_done) begin
                  state_ff <= ST_ADDR;
               end
            end
            ST_ADDR: begin
               scan_idx_ff <= '0;
               if (!stat.op && stat.explore) begin
                  res_sel_ff <= RES_RAND;
                  state_ff   <= ST_RESULT;
               end else begin
                  row_next_ff <= stat.op;
                  res_sel_ff  <= stat.op ? RES_UPD : RES_BEST;
                  state_ff    <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (scan_idx_ff == live - CW'(1)) begin
                  state_ff <= ST_SCAN_WAIT;
               end else begin
                  scan_idx_ff <= scan_idx_ff + CW'(1);
               end
            end
            ST_SCAN_WAIT: state_ff <= stat.op ? ST_RDQ : ST_RESULT;
            ST_RDQ:       state_ff <= ST_QLAT;
            ST_QLAT:      state_ff <= ST_TGT;
            ST_TGT:       state_ff <= ST_MUL2;
            ST_MUL2:      state_ff <= ST_SUM;
            ST_SUM:       state_ff <= ST_WR;
            ST_WR:        state_ff <= ST_RESULT;
            ST_RESULT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // table clear runs right after reset, no item taken meanwhile
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready) else $error("item taken during clear");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second item taken");

   a_wr_after_sum: assert property (@(posedge clock) disable iff (reset)
      cmd.q_wr |-> $past(cmd.sum)) else $error("write-back without new value");
`endif

endmodule

// ----- rtl/tabular_q_learning_engine_unit.sv -----
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_unit
// One item at a time: every item runs the 16-step pick reduction; a greedy choose
// then scans the current state's row, an update the next state's row, through the
// single Q table read port. A result still held by rsp_ready keeps the next item
// waiting in its result step.
// Reset: synchronous; then a clearing pass over all NUM_STATES*NUM_ACTIONS entries
// zeroes the table with req_ready low; config writes are taken throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tabular_q_learning_engine_unit import tqle_pkg::*; #(
   parameter int NUM_STATES  = 1024,
   parameter int NUM_ACTIONS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_data
);

   localparam int AIW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
   localparam int CW  = $clog2(NUM_ACTIONS + 1);

   cmd_type        cmd;
   stat_type       stat;
   logic [CW-1:0]  live;
   logic [AIW-1:0] scan_idx;

   assign csr_ready = 1'b1;

   tqle_dp #(.NUM_STATES(NUM_STATES), .NUM_ACTIONS(NUM_ACTIONS)) u_dp (
      .clock(clock), .reset(reset), .req_data(req_data),
      .csr_we(csr_valid && csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .scan_idx(scan_idx), .stat(stat), .live(live), .rsp_data(rsp_data)
   );

   tqle_ctrl #(.NUM_ACTIONS(NUM_ACTIONS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .live(live),
      .cmd(cmd), .scan_idx(scan_idx)
   );

endmodule
